@@ hdl/bgc_pkg.sv @@
// ----------------------------------------------------------------------------
// bgc_pkg: shared types and constants of the button gesture classifier
// Phase and indicator codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

  // widths
  localparam int unsigned CountWidthDefault = 17;
  localparam int unsigned LimitWidth        = 16;
  localparam int unsigned CodeWidth         = 3;
  localparam int unsigned CfgIndexWidth     = 8;

  // phase codes
  typedef enum logic [CodeWidth-1:0] {
    PhIdle   = 3'd0,
    PhFirst  = 3'd1,
    PhHold   = 3'd2,
    PhSecond = 3'd3,
    PhInd    = 3'd4
  } phase_e;

  // indicator codes
  typedef enum logic [CodeWidth-1:0] {
    IndNone   = 3'd0,
    IndSingle = 3'd1,
    IndDouble = 3'd2,
    IndShort  = 3'd3,
    IndLong   = 3'd4
  } ind_e;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] RegShortHold  = 8'd0;
  localparam logic [CfgIndexWidth-1:0] RegLongHold   = 8'd1;
  localparam logic [CfgIndexWidth-1:0] RegDoubleWin  = 8'd2;
  localparam logic [CfgIndexWidth-1:0] RegIndTime    = 8'd3;

  // configuration reset values
  localparam logic [LimitWidth-1:0] ShortHoldReset = 16'd500;
  localparam logic [LimitWidth-1:0] LongHoldReset  = 16'd2000;
  localparam logic [LimitWidth-1:0] DoubleWinReset = 16'd300;
  localparam logic [LimitWidth-1:0] IndTimeReset   = 16'd2000;

endpackage

`default_nettype wire

@@ hdl/button_gesture_classifier_top.sv @@
// ----------------------------------------------------------------------------
// button_gesture_classifier_top: push-button gesture classifier
// Sorts presses into single, double, short hold and long hold and lights the
// matching indicator for a configured number of ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on the in channel (in_valid_i / in_stall_o) is one tick
//   carrying the sampled button level pressed_i. Every accepted word yields
//   exactly one result word on the out channel (out_valid_o / out_stall_i)
//   with the lit indicator code and the phase after that tick.
//   The classification is one pass of compare-and-count logic from the state
//   registers into the output register, or into the skid register while a
//   result is stalled; one word is accepted every cycle while in_stall_o is low.
//   A two-entry output stage (output register plus skid register) lets the
//   block take one more word while a result is stalled; in_stall_o rises only
//   once both entries are full, and results leave in order.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes the four
//   16-bit limits by index; indexes beyond the list are ignored. Writes are
//   taken in every cycle and should be made while the block is idle.
//   Reset clears the phase to idle, the counters, the indicator and both
//   output entries, and loads the default limits.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_classifier_top #(
  parameter int unsigned COUNT_WIDTH = bgc_pkg::CountWidthDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               pressed_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [bgc_pkg::CodeWidth-1:0]           lit_indicator_o,
  output logic [bgc_pkg::CodeWidth-1:0]           phase_o,
  // configuration channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bgc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  wire logic [bgc_pkg::LimitWidth-1:0]     cfg_data_i
);

  localparam int unsigned LimW = bgc_pkg::LimitWidth;
  localparam int unsigned CmpW = (COUNT_WIDTH > LimW) ? COUNT_WIDTH : LimW;
  localparam int unsigned CodeW = bgc_pkg::CodeWidth;

  // configuration registers
  logic [LimW-1:0] short_hold_q, long_hold_q, double_win_q, ind_time_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_hold_q <= bgc_pkg::ShortHoldReset;
      long_hold_q  <= bgc_pkg::LongHoldReset;
      double_win_q <= bgc_pkg::DoubleWinReset;
      ind_time_q   <= bgc_pkg::IndTimeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bgc_pkg::RegShortHold: short_hold_q <= cfg_data_i;
        bgc_pkg::RegLongHold:  long_hold_q  <= cfg_data_i;
        bgc_pkg::RegDoubleWin: double_win_q <= cfg_data_i;
        bgc_pkg::RegIndTime:   ind_time_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // gesture state
  bgc_pkg::phase_e          phase_q, phase_d;
  bgc_pkg::ind_e            chosen_q, chosen_d;
  logic                     ind_on_q, ind_on_d;
  logic [COUNT_WIDTH-1:0]   press_cnt_q, press_cnt_d;
  logic [COUNT_WIDTH-1:0]   ind_cnt_q, ind_cnt_d;

  // handshake
  logic in_acc;
  logic skid_valid_q;
  logic out_valid_q;

  assign in_acc   = in_valid_i && !in_stall_o;

  // counters advanced ahead of the compares
  logic                   press_run;
  logic                   ind_run;
  logic [COUNT_WIDTH-1:0] press_adv;
  logic [COUNT_WIDTH-1:0] ind_adv;
  logic [CmpW-1:0]        press_ext, ind_ext;

  assign press_run = (phase_q == bgc_pkg::PhFirst) || (phase_q == bgc_pkg::PhHold) ||
                     (phase_q == bgc_pkg::PhSecond);
  assign ind_run   = (phase_q == bgc_pkg::PhInd) && ind_on_q;

  assign press_adv = (press_run && (press_cnt_q != '1)) ? press_cnt_q + 1'b1 : press_cnt_q;
  assign ind_adv   = (ind_run && (ind_cnt_q != '1)) ? ind_cnt_q + 1'b1 : ind_cnt_q;

  assign press_ext = CmpW'(press_adv);
  assign ind_ext   = CmpW'(ind_adv);

  // next gesture state for one tick
  always_comb begin
    phase_d     = phase_q;
    chosen_d    = chosen_q;
    ind_on_d    = ind_on_q;
    press_cnt_d = press_adv;
    ind_cnt_d   = ind_adv;
    unique case (phase_q)
      bgc_pkg::PhFirst: begin
        if (press_ext > CmpW'(short_hold_q)) begin
          phase_d = bgc_pkg::PhHold;
        end else if (!pressed_i) begin
          phase_d = bgc_pkg::PhSecond;
        end
      end
      bgc_pkg::PhHold: begin
        if (!pressed_i) begin
          chosen_d = (press_ext < CmpW'(long_hold_q)) ? bgc_pkg::IndShort
                                                      : bgc_pkg::IndLong;
          phase_d  = bgc_pkg::PhInd;
        end
      end
      bgc_pkg::PhSecond: begin
        if (pressed_i) begin
          chosen_d = bgc_pkg::IndDouble;
          phase_d  = bgc_pkg::PhInd;
        end else if (press_ext > CmpW'(double_win_q)) begin
          chosen_d = bgc_pkg::IndSingle;
          phase_d  = bgc_pkg::PhInd;
        end
      end
      bgc_pkg::PhInd: begin
        if (!pressed_i) begin
          if (!ind_on_q) begin
            ind_on_d  = 1'b1;
            ind_cnt_d = '0;
          end else if (ind_ext > CmpW'(ind_time_q)) begin
            ind_on_d = 1'b0;
            phase_d  = bgc_pkg::PhIdle;
          end
        end
      end
      default: begin
        // idle, and any stray code is treated as idle
        phase_d = bgc_pkg::PhIdle;
        if (pressed_i) begin
          press_cnt_d = '0;
          phase_d     = bgc_pkg::PhFirst;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bgc_pkg::PhIdle;
      chosen_q    <= bgc_pkg::IndNone;
      ind_on_q    <= 1'b0;
      press_cnt_q <= '0;
      ind_cnt_q   <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      chosen_q    <= chosen_d;
      ind_on_q    <= ind_on_d;
      press_cnt_q <= press_cnt_d;
      ind_cnt_q   <= ind_cnt_d;
    end
  end

  // result word of this tick
  logic [CodeW-1:0] res_lit, res_phase;

  assign res_lit   = ind_on_d ? CodeW'(chosen_d) : CodeW'(bgc_pkg::IndNone);
  assign res_phase = CodeW'(phase_d);

  // output register and skid register
  logic [CodeW-1:0] out_lit_q, out_phase_q;
  logic [CodeW-1:0] skid_lit_q, skid_phase_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= skid_valid_q || in_acc;
      end
      if (skid_valid_q && out_free) begin
        skid_valid_q <= 1'b0;
      end else if (in_acc && !out_free) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_lit_q   <= skid_lit_q;
        out_phase_q <= skid_phase_q;
      end else if (in_acc) begin
        out_lit_q   <= res_lit;
        out_phase_q <= res_phase;
      end
    end
    if (in_acc && !out_free) begin
      skid_lit_q   <= res_lit;
      skid_phase_q <= res_phase;
    end
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign lit_indicator_o = out_lit_q;
  assign phase_o         = out_phase_q;

  // checks on the classifier state and the output stage
  a_lit_only_in_ind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ind_on_q |-> (phase_q == bgc_pkg::PhInd))
    else $error("indicator lit outside the indicator phase");

  a_ind_has_choice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bgc_pkg::PhInd) |-> (chosen_q != bgc_pkg::IndNone))
    else $error("indicator phase entered without a gesture");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("accepted word lost while output stalled");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the button gesture classifier
// Drives button ticks with bursty valid and a patterned output stall, keeps
// its own gesture model in step with every accepted word and compares each
// result word (lit indicator and phase) with the model or a typed row's value.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CntW          = bgc_pkg::CountWidthDefault;
  localparam int unsigned LimW          = bgc_pkg::LimitWidth;
  localparam int unsigned CfgW          = bgc_pkg::CfgIndexWidth;
  localparam int unsigned CodeW         = bgc_pkg::CodeWidth;
  localparam int unsigned DirRows       = 26;
  localparam int unsigned DirSetupRow   = 2;
  localparam int unsigned RandPhases    = 10;
  localparam int unsigned TicksPerPhase = 92;
  localparam int unsigned SqueezePhase  = 3;
  localparam int unsigned LongHoldOff   = 40;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned TimeLimit     = 4_000_000;

  typedef struct packed {
    bgc_pkg::ind_e   lit;
    bgc_pkg::phase_e phase;
  } tick_result_t;

  typedef struct packed {
    logic         pressed;
    logic         typed;
    tick_result_t want;
  } dir_row_t;

  localparam tick_result_t NoCheck = '{bgc_pkg::IndNone, bgc_pkg::PhIdle};

  bit                      clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    pressed;
  logic                    out_valid;
  logic                    out_stall;
  logic [CodeW-1:0]        lit_ind;
  logic [CodeW-1:0]        phase_out;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgW-1:0]         cfg_index;
  logic [LimW-1:0]         cfg_data;

  // gesture model state and limits
  bgc_pkg::phase_e         mdl_phase;
  logic [CntW-1:0]         mdl_press_ticks;
  logic [CntW-1:0]         mdl_lit_ticks;
  bgc_pkg::ind_e           mdl_chosen;
  logic                    mdl_lit_on;
  logic [LimW-1:0]         lim_short_hold;
  logic [LimW-1:0]         lim_long_hold;
  logic [LimW-1:0]         lim_double_win;
  logic [LimW-1:0]         lim_lit_time;

  tick_result_t            pending_results [$];
  int unsigned             mismatch_count;
  int unsigned             burst_left;
  bit                      squeeze_req;

  // directed gestures: reset ticks, then single, double, short hold, long hold
  dir_row_t dir_rows [DirRows] = '{
    '{1'b0, 1'b1, '{bgc_pkg::IndNone, bgc_pkg::PhIdle}},
    '{1'b1, 1'b1, '{bgc_pkg::IndNone, bgc_pkg::PhFirst}},
    '{1'b0, 1'b0, NoCheck}, '{1'b0, 1'b0, NoCheck},
    '{1'b0, 1'b0, NoCheck}, '{1'b0, 1'b0, NoCheck},
    '{1'b1, 1'b0, NoCheck}, '{1'b0, 1'b0, NoCheck},
    '{1'b1, 1'b0, NoCheck}, '{1'b1, 1'b0, NoCheck},
    '{1'b0, 1'b0, NoCheck}, '{1'b1, 1'b0, NoCheck},
    '{1'b0, 1'b0, NoCheck},
    '{1'b1, 1'b0, NoCheck}, '{1'b1, 1'b0, NoCheck},
    '{1'b1, 1'b0, NoCheck}, '{1'b0, 1'b0, NoCheck},
    '{1'b0, 1'b0, NoCheck}, '{1'b0, 1'b0, NoCheck},
    '{1'b1, 1'b0, NoCheck}, '{1'b1, 1'b0, NoCheck},
    '{1'b1, 1'b0, NoCheck}, '{1'b1, 1'b0, NoCheck},
    '{1'b0, 1'b0, NoCheck}, '{1'b0, 1'b0, NoCheck},
    '{1'b0, 1'b0, NoCheck}
  };

  button_gesture_classifier_top #(
    .COUNT_WIDTH(CntW)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pressed_i      (pressed),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .lit_indicator_o(lit_ind),
    .phase_o        (phase_out),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #(TimeLimit);
    $display("Mismatches found");
    $finish;
  end

  // one tick of the gesture model: counters advance first, then the compare
  task automatic step_gesture_model(input logic lvl, output tick_result_t res);
    if (mdl_phase inside {bgc_pkg::PhFirst, bgc_pkg::PhHold, bgc_pkg::PhSecond} &&
        mdl_press_ticks != '1) begin
      mdl_press_ticks++;
    end
    if (mdl_phase == bgc_pkg::PhInd && mdl_lit_on && mdl_lit_ticks != '1) begin
      mdl_lit_ticks++;
    end
    case (mdl_phase)
      bgc_pkg::PhFirst: begin
        if (mdl_press_ticks > CntW'(lim_short_hold)) mdl_phase = bgc_pkg::PhHold;
        else if (!lvl) mdl_phase = bgc_pkg::PhSecond;
      end
      bgc_pkg::PhHold: begin
        if (!lvl) begin
          if (mdl_press_ticks < CntW'(lim_long_hold)) mdl_chosen = bgc_pkg::IndShort;
          else mdl_chosen = bgc_pkg::IndLong;
          mdl_phase = bgc_pkg::PhInd;
        end
      end
      bgc_pkg::PhSecond: begin
        if (lvl) begin
          mdl_chosen = bgc_pkg::IndDouble;
          mdl_phase  = bgc_pkg::PhInd;
        end else if (mdl_press_ticks > CntW'(lim_double_win)) begin
          mdl_chosen = bgc_pkg::IndSingle;
          mdl_phase  = bgc_pkg::PhInd;
        end
      end
      bgc_pkg::PhInd: begin
        // a held button freezes everything but a lit counter
        if (!lvl) begin
          if (!mdl_lit_on) begin
            mdl_lit_on    = 1'b1;
            mdl_lit_ticks = '0;
          end else if (mdl_lit_ticks > CntW'(lim_lit_time)) begin
            mdl_lit_on = 1'b0;
            mdl_phase  = bgc_pkg::PhIdle;
          end
        end
      end
      default: begin
        mdl_phase = bgc_pkg::PhIdle;
        if (lvl) begin
          mdl_press_ticks = '0;
          mdl_phase       = bgc_pkg::PhFirst;
        end
      end
    endcase
    if (mdl_lit_on) res.lit = mdl_chosen;
    else res.lit = bgc_pkg::IndNone;
    res.phase = mdl_phase;
  endtask

  // offer one tick word, with random gaps between bursts
  task automatic send_tick(input logic lvl, input logic typed, input tick_result_t want);
    int unsigned  gap;
    tick_result_t got;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pressed  <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_gesture_model(lvl, got);
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // one register write; valid stays high for a following write
  task automatic write_reg(input logic [CfgW-1:0] idx,
                           input logic [LimW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bgc_pkg::RegShortHold: lim_short_hold = val;
      bgc_pkg::RegLongHold:  lim_long_hold  = val;
      bgc_pkg::RegDoubleWin: lim_double_win = val;
      bgc_pkg::RegIndTime:   lim_lit_time   = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // all four limits plus one write to an index past the list
  task automatic program_limits(input logic [LimW-1:0] hold_lim,
                                input logic [LimW-1:0] long_lim,
                                input logic [LimW-1:0] win_lim,
                                input logic [LimW-1:0] lit_lim);
    write_reg(bgc_pkg::RegShortHold, hold_lim);
    write_reg(bgc_pkg::RegLongHold, long_lim);
    write_reg(bgc_pkg::RegDoubleWin, win_lim);
    write_reg(bgc_pkg::RegIndTime, lit_lim);
    write_reg(CfgW'($urandom_range(4, 255)), LimW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off to fill the block
  initial begin : stall_pattern
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    bit          squeezed;
    bit          s;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    squeezed  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      if (!squeezed && squeeze_req) begin
        squeezed  = 1'b1;
        hold_left = LongHoldOff;
      end
      case (mode)
        0: s = 1'b0;
        1: s = ($urandom_range(0, 9) < 3);
        2: s = ($urandom_range(0, 9) < 7);
        default: s = seg_left[0];
      endcase
      if (hold_left != 0) begin
        s = 1'b1;
        hold_left--;
      end
      out_stall <= s;
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    tick_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: lit_indicator %0d, phase %0d",
               lit_ind, phase_out);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (lit_ind !== exp_r.lit) begin
          $error("lit_indicator: expected %0d, got %0d", exp_r.lit, lit_ind);
          mismatch_count++;
        end
        if (phase_out !== exp_r.phase) begin
          $error("phase: expected %0d, got %0d", exp_r.phase, phase_out);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [LimW-1:0]       hs, hl, dw, lt;
    int unsigned           span, top, run, sent;
    logic                  lvl;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    pressed   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    mdl_phase       = bgc_pkg::PhIdle;
    mdl_press_ticks = '0;
    mdl_lit_ticks   = '0;
    mdl_chosen      = bgc_pkg::IndNone;
    mdl_lit_on      = 1'b0;
    lim_short_hold  = bgc_pkg::ShortHoldReset;
    lim_long_hold   = bgc_pkg::LongHoldReset;
    lim_double_win  = bgc_pkg::DoubleWinReset;
    lim_lit_time    = bgc_pkg::IndTimeReset;
    mismatch_count  = 0;
    burst_left      = 0;
    squeeze_req     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: first ticks at the reset limits, then tight limits
    for (int i = 0; i < DirRows; i++) begin
      if (i == DirSetupRow) begin
        drain_results();
        program_limits(16'd1, 16'd4, 16'd1, 16'd0);
      end
      send_tick(dir_rows[i].pressed, dir_rows[i].typed, dir_rows[i].want);
    end

    // random: alternating press and release runs under varied limits
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain_results();
      if (ph == 0) begin
        hs = '0; hl = '0; dw = '0; lt = '0;
      end else if (ph == 1) begin
        hs = '1; hl = '1; dw = '1; lt = '1;
      end else begin
        hs = LimW'($urandom_range(0, 6));
        hl = LimW'($urandom_range(0, 12));
        dw = LimW'($urandom_range(0, 6));
        lt = LimW'($urandom_range(0, 6));
        if ($urandom_range(0, 5) == 0) begin
          case ($urandom_range(0, 3))
            0: hs = '1;
            1: hl = '1;
            2: dw = '1;
            default: lt = '1;
          endcase
        end
      end
      program_limits(hs, hl, dw, lt);
      // long receiver hold-off while this whole phase is still to be offered
      if (ph == SqueezePhase) begin
        squeeze_req = 1'b1;
      end
      // run lengths scaled to the largest limit, capped when that limit is large
      top = 32'(hs);
      if (hl > top) top = 32'(hl);
      if (dw > top) top = 32'(dw);
      if (lt > top) top = 32'(lt);
      span = (top > 20) ? 24 : top + 3;
      lvl  = 1'($urandom_range(0, 1));
      sent = 0;
      while (sent < TicksPerPhase) begin
        run = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, span);
        for (int k = 0; k < run; k++) begin
          send_tick(lvl, 1'b0, NoCheck);
          sent++;
        end
        lvl = ~lvl;
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
